// ----- hw/rtl/tbs_pkg.sv -----
// tbs_pkg: field widths, status codes and register indexes of the token bucket shaper
// no dependencies; every other file of the block but tbs_ram uses it
package tbs_pkg;

  localparam int LEVEL_W    = 10;  // bucket level and bucket depth
  localparam int NEED_IN_W  = 10;  // tokens_needed field
  localparam int NUM_W      = 16;  // packet numbers and packet limit
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_TOO_BIG    = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_TOKEN_ADD  = 3'd4,
    ST_TOKEN_DROP = 3'd5
  } status_t;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_DEPTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 4'd1;

  localparam logic [LEVEL_W-1:0] BUCKET_DEPTH_RST = 10'd10;
  localparam logic [NUM_W-1:0]   PACKET_LIMIT_RST = 16'd20;

endpackage

// ----- hw/rtl/tbs_in_if.sv -----
// tbs_in_if: input channel of the shaper, one token tick or packet arrival per transfer
// depends on tbs_pkg
interface tbs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tbs_pkg::NEED_IN_W-1:0] tokens_needed;

  modport source (output valid, output kind, output tokens_needed, input ready);
  modport sink   (input valid, input kind, input tokens_needed, output ready);
endinterface

// ----- hw/rtl/tbs_out_if.sv -----
// tbs_out_if: result channel of the shaper, one result per input transfer
// depends on tbs_pkg
interface tbs_out_if;
  logic                        valid;
  logic                        ready;
  tbs_pkg::status_t            status;
  logic [tbs_pkg::NUM_W-1:0]   packet_number;
  logic                        released;
  logic [tbs_pkg::NUM_W-1:0]   released_number;
  logic [tbs_pkg::LEVEL_W-1:0] bucket_level;

  modport source (output valid, output status, output packet_number, output released,
                  output released_number, output bucket_level, input ready);
  modport sink   (input valid, input status, input packet_number, input released,
                  input released_number, input bucket_level, output ready);
endinterface

// ----- hw/rtl/tbs_cfg_if.sv -----
// tbs_cfg_if: register write channel of the shaper
// depends on tbs_pkg
interface tbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tbs_pkg::CFG_IDX_W-1:0]    index;
  logic [tbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/token_bucket_shaper.sv -----
// token_bucket_shaper: every item goes through accept and then head check; one item at a time
// the waiting-packet fifo lives in a ram with registered read, so the head check follows the accept
// the result is written into the output register from the head check, once that register is free
// a new item is taken while the last result still waits for its transfer
// rst_n (synchronous) empties the fifo and bucket and restores the register defaults
// the fifo ram needs no clearing: only entries below the fill count are ever read
module token_bucket_shaper #(
  parameter int QUEUE_DEPTH = 64,
  parameter int NEED_BITS   = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  tbs_in_if.sink     in_if,
  tbs_out_if.source  out_if,
  tbs_cfg_if.sink    cfg_if
);
  import tbs_pkg::*;

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EW    = NUM_W + NEED_BITS;
  // compare width that holds both a stored need and the bucket level
  localparam int CW    = (NEED_BITS > LEVEL_W) ? NEED_BITS : LEVEL_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // configuration registers
  logic [LEVEL_W-1:0] bucket_depth;
  logic [NUM_W-1:0]   packet_limit;

  tbs_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_if       (cfg_if),
    .bucket_depth (bucket_depth),
    .packet_limit (packet_limit)
  );

  // control state
  state_t             state_r, state_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [NUM_W-1:0]   counter_r, counter_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // per-item payload carried from the accept cycle into the head check
  status_t            status_r, status_nxt;
  logic [NUM_W-1:0]   number_r, number_nxt;
  logic               fwd_r, fwd_nxt;
  logic [EW-1:0]      fwd_data_r, fwd_data_nxt;

  // output register payload
  status_t            o_status_r, o_status_nxt;
  logic [NUM_W-1:0]   o_number_r, o_number_nxt;
  logic               o_rel_r, o_rel_nxt;
  logic [NUM_W-1:0]   o_rel_num_r, o_rel_num_nxt;
  logic [LEVEL_W-1:0] o_level_r, o_level_nxt;

  // fifo ram: {packet number, need}
  logic               ram_we;
  logic [EW-1:0]      ram_wdata;
  logic               ram_re;
  logic [EW-1:0]      ram_rdata;

  tbs_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  logic                 accept;
  logic [NUM_W:0]       counter_inc;
  logic [LEVEL_W:0]     level_inc;
  logic [NEED_BITS-1:0] need_in;
  logic [EW-1:0]        head_entry;
  logic [NEED_BITS-1:0] head_need;
  logic                 release_ok;
  logic                 out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;

  assign counter_inc = {1'b0, counter_r} + 1'b1;
  assign level_inc   = {1'b0, level_r} + 1'b1;
  assign need_in     = NEED_BITS'(in_if.tokens_needed);
  assign ram_wdata   = {counter_inc[NUM_W-1:0], need_in};
  // head read is issued at every accept, it lands for the head check
  assign ram_re      = accept;

  // an entry written into an empty fifo is the head itself: take it from the bypass
  assign head_entry  = fwd_r ? fwd_data_r : ram_rdata;
  assign head_need   = head_entry[NEED_BITS-1:0];
  assign release_ok  = (count_r != '0) && (CW'(head_need) <= CW'(level_r));

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    counter_nxt   = counter_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    number_nxt    = number_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    o_status_nxt  = o_status_r;
    o_number_nxt  = o_number_r;
    o_rel_nxt     = o_rel_r;
    o_rel_num_nxt = o_rel_num_r;
    o_level_nxt   = o_level_r;
    ram_we        = 1'b0;

    // result taken by the sink
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_EXEC;
          number_nxt   = '0;
          fwd_nxt      = 1'b0;
          fwd_data_nxt = ram_wdata;
          if (in_if.kind == KIND_TICK) begin
            // bucket grows by one unless it is at or above its depth
            if (level_inc <= {1'b0, bucket_depth}) begin
              level_nxt  = level_inc[LEVEL_W-1:0];
              status_nxt = ST_TOKEN_ADD;
            end else begin
              status_nxt = ST_TOKEN_DROP;
            end
          end else if (counter_inc > {1'b0, packet_limit}) begin
            // arrival past the limit: no number used
            status_nxt = ST_IGNORED;
          end else begin
            counter_nxt = counter_inc[NUM_W-1:0];
            number_nxt  = counter_inc[NUM_W-1:0];
            if (in_if.tokens_needed > bucket_depth) begin
              status_nxt = ST_TOO_BIG;
            end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              status_nxt = ST_QUEUE_FULL;
            end else begin
              ram_we     = 1'b1;
              fwd_nxt    = (count_r == '0);
              tail_nxt   = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_QUEUED;
            end
          end
        end
      end
      S_EXEC: begin
        // ram read data and the bypass hold while the output register is busy
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_number_nxt  = number_r;
          o_rel_nxt     = release_ok;
          o_rel_num_nxt = '0;
          o_level_nxt   = level_r;
          if (release_ok) begin
            level_nxt     = level_r - LEVEL_W'(head_need);
            o_level_nxt   = level_r - LEVEL_W'(head_need);
            o_rel_num_nxt = head_entry[EW-1:NEED_BITS];
            head_nxt      = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt     = count_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      counter_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      counter_r   <= counter_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset needed
    status_r    <= status_nxt;
    number_r    <= number_nxt;
    fwd_r       <= fwd_nxt;
    fwd_data_r  <= fwd_data_nxt;
    o_status_r  <= o_status_nxt;
    o_number_r  <= o_number_nxt;
    o_rel_r     <= o_rel_nxt;
    o_rel_num_r <= o_rel_num_nxt;
    o_level_r   <= o_level_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = o_status_r;
  assign out_if.packet_number   = o_number_r;
  assign out_if.released        = o_rel_r;
  assign out_if.released_number = o_rel_num_r;
  assign out_if.bucket_level    = o_level_r;

endmodule

// ----- hw/rtl/tbs_ram.sv -----
// tbs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tbs_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tbs_cfg_regs.sv -----
// tbs_cfg_regs: bucket depth and packet limit registers behind the write channel
// depends on tbs_pkg and tbs_cfg_if
module tbs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  tbs_cfg_if.sink                     cfg_if,
  output logic [tbs_pkg::LEVEL_W-1:0] bucket_depth,
  output logic [tbs_pkg::NUM_W-1:0]   packet_limit
);
  import tbs_pkg::*;

  logic [LEVEL_W-1:0] bucket_depth_r;
  logic [NUM_W-1:0]   packet_limit_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_depth_r <= BUCKET_DEPTH_RST;
      packet_limit_r <= PACKET_LIMIT_RST;
    end else if (cfg_if.valid) begin
      // writes to unknown indexes fall through
      case (cfg_if.index)
        CFG_BUCKET_DEPTH: bucket_depth_r <= cfg_if.data[LEVEL_W-1:0];
        CFG_PACKET_LIMIT: packet_limit_r <= cfg_if.data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign bucket_depth = bucket_depth_r;
  assign packet_limit = packet_limit_r;

endmodule

// ----- hw/rtl/tbs_checker.sv -----
// tbs_checker: port-level assertions for token_bucket_shaper, bound to the top level
// depends on tbs_pkg and token_bucket_shaper
module tbs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tbs_pkg::STATUS_W-1:0] out_status,
  input logic [tbs_pkg::NUM_W-1:0]   out_packet_number,
  input logic                        out_released,
  input logic [tbs_pkg::NUM_W-1:0]   out_released_number,
  input logic [tbs_pkg::LEVEL_W-1:0] out_bucket_level
);
  import tbs_pkg::*;

  // no result leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: an input transfer is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken in the cycle after a transfer");

  // token ticks and ignored arrivals carry no packet number, no release means no released number
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_released || out_released_number == '0) &&
                  ((out_status != ST_TOKEN_ADD && out_status != ST_TOKEN_DROP &&
                    out_status != ST_IGNORED) || out_packet_number == '0))
    else $error("number field not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_status) && $stable(out_packet_number) &&
      $stable(out_released) && $stable(out_released_number) && $stable(out_bucket_level))
    else $error("stalled result changed");

endmodule

bind token_bucket_shaper tbs_checker u_tbs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_if.valid),
  .in_ready            (in_if.ready),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_status          (out_if.status),
  .out_packet_number   (out_if.packet_number),
  .out_released        (out_if.released),
  .out_released_number (out_if.released_number),
  .out_bucket_level    (out_if.bucket_level)
);

// ----- verif/token_bucket_shaper_checker.sv -----
// token_bucket_shaper_checker: watches the input, result and register channels of the shaper,
// predicts every result from its own copy of the bucket and fifo state and compares it
// depends on tbs_pkg and the tbs_in_if, tbs_out_if and tbs_cfg_if interfaces
module token_bucket_shaper_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  tbs_in_if    in_ch,
  tbs_out_if   out_ch,
  tbs_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   pending_results,
  output int   bucket_tokens,
  output int   queued_packets,
  output int   packets_numbered
);
  import tbs_pkg::*;

  typedef struct {
    logic [NUM_W-1:0]     number;
    logic [NEED_IN_W-1:0] need;
  } waiting_pkt_t;

  typedef struct {
    status_t              status;
    logic [NUM_W-1:0]     packet_number;
    logic                 released;
    logic [NUM_W-1:0]     released_number;
    logic [LEVEL_W-1:0]   bucket_level;
  } shaped_result_t;

  logic [LEVEL_W-1:0] depth_reg;
  logic [NUM_W-1:0]   limit_reg;
  logic [LEVEL_W-1:0] level;
  logic [NUM_W-1:0]   counter;
  waiting_pkt_t       waiting_fifo[$];
  shaped_result_t     awaited_results[$];
  shaped_result_t     oldest;
  int                 errs = 0;

  function automatic shaped_result_t shape_item(logic kind, logic [NEED_IN_W-1:0] need);
    shaped_result_t r;
    waiting_pkt_t   head;
    r.packet_number   = '0;
    r.released        = 1'b0;
    r.released_number = '0;
    if (kind == KIND_TICK) begin
      if ({1'b0, level} + 11'd1 <= {1'b0, depth_reg}) begin
        level    = level + 1'b1;
        r.status = ST_TOKEN_ADD;
      end else begin
        r.status = ST_TOKEN_DROP;
      end
    end else if ({1'b0, counter} + 17'd1 > {1'b0, limit_reg}) begin
      r.status = ST_IGNORED;
    end else begin
      counter         = counter + 1'b1;
      r.packet_number = counter;
      if (need > depth_reg) begin
        r.status = ST_TOO_BIG;
      end else if (waiting_fifo.size() >= QUEUE_DEPTH) begin
        r.status = ST_QUEUE_FULL;
      end else begin
        waiting_fifo.push_back('{number: counter, need: need});
        r.status = ST_QUEUED;
      end
    end
    // at most one release per item, strictly from the head
    if (waiting_fifo.size() > 0 && waiting_fifo[0].need <= level) begin
      head              = waiting_fifo.pop_front();
      level             = level - head.need;
      r.released        = 1'b1;
      r.released_number = head.number;
    end
    r.bucket_level = level;
    return r;
  endfunction

  function automatic void check_field(string field, logic [NUM_W-1:0] want,
                                      logic [NUM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_reg = BUCKET_DEPTH_RST;
      limit_reg = PACKET_LIMIT_RST;
      level     = '0;
      counter   = '0;
      waiting_fifo.delete();
      awaited_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BUCKET_DEPTH: depth_reg = cfg_ch.data[LEVEL_W-1:0];
          CFG_PACKET_LIMIT: limit_reg = cfg_ch.data[NUM_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(shape_item(in_ch.kind, in_ch.tokens_needed));
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no result awaited (status %0d)", out_ch.status);
          errs++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", NUM_W'(oldest.status), NUM_W'(out_ch.status));
          check_field("packet_number", oldest.packet_number, out_ch.packet_number);
          check_field("released", NUM_W'(oldest.released), NUM_W'(out_ch.released));
          check_field("released_number", oldest.released_number, out_ch.released_number);
          check_field("bucket_level", NUM_W'(oldest.bucket_level),
                      NUM_W'(out_ch.bucket_level));
        end
      end
    end
    mismatch_count   <= errs;
    pending_results  <= awaited_results.size();
    bucket_tokens    <= int'(level);
    queued_packets   <= waiting_fifo.size();
    packets_numbered <= int'(counter);
  end

endmodule

// ----- verif/token_bucket_shaper_test.sv -----
// token_bucket_shaper_test: top of the shaper testbench; drives token ticks, packet arrivals
// and register writes through phases of differing pacing, the checker does the comparing
// depends on tbs_pkg, the three channel interfaces, token_bucket_shaper and its checker
module token_bucket_shaper_test;
  import tbs_pkg::*;

  // cycles with no transfer on any channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = 4'd15;

  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  logic clk;
  logic rst_n;

  tbs_in_if  in_if();
  tbs_out_if out_if();
  tbs_cfg_if cfg_if();

  int mismatch_count;
  int pending_results;
  int bucket_tokens;
  int queued_packets;
  int packets_numbered;

  int gap_pct;
  int stall_pct;
  int cur_depth;
  int items_sent;
  int reg_writes;
  int phases;
  int idle_cycles;
  int n;
  int k;

  token_bucket_shaper DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  token_bucket_shaper_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .cfg_ch          (cfg_if),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .bucket_tokens   (bucket_tokens),
    .queued_packets  (queued_packets),
    .packets_numbered(packets_numbered)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: ready drops at random according to the current pacing
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("token_bucket_shaper_test: FAIL");
      $finish;
    end
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        gap_pct = 0;  stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        gap_pct = 66; stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        gap_pct = 0;  stall_pct = 66;
      end
      default: begin
        gap_pct = 22; stall_pct = 22;
      end
    endcase
  endtask

  // one input transfer; valid stays high on return so back-to-back items need no extra step
  task automatic send_item(input logic kind, input logic [NEED_IN_W-1:0] need);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= kind;
    in_if.tokens_needed <= need;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // register write; valid is left high so consecutive writes chain, end_writes drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending, let every awaited result come out, then let the block sit idle before the phase is counted
  task automatic finish_phase(input int settle);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    phases++;
  endtask

  // needs mostly small so the fifo keeps draining, some oversized to hit the drop path
  function automatic logic [NEED_IN_W-1:0] pick_need(input int depth);
    int r;
    r = $urandom_range(99);
    if (r < 70) return NEED_IN_W'($urandom_range(depth < 2 ? depth : 2, 0));
    if (r < 80) return NEED_IN_W'($urandom_range(depth < 16 ? depth : 16, 0));
    if (depth < 1023) return NEED_IN_W'($urandom_range(1023, depth + 1));
    return NEED_IN_W'($urandom_range(3, 0));
  endfunction

  task automatic run_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55) send_item(KIND_TICK, NEED_IN_W'($urandom));
      else send_item(KIND_PACKET, pick_need(cur_depth));
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.kind          <= KIND_PACKET;
    in_if.tokens_needed <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_BUCKET_DEPTH;
    cfg_if.data         <= '0;
    items_sent          = 0;
    reg_writes          = 0;
    phases              = 0;
    cur_depth           = int'(BUCKET_DEPTH_RST);
    set_pace(PACE_FULL);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset settings: depth 10, limit 20
    send_item(KIND_TICK, '0);                 // first token
    send_item(KIND_PACKET, '0);               // zero need, leaves at once
    send_item(KIND_PACKET, '1);               // largest need, too big
    send_item(KIND_PACKET, 10'd11);           // just over the depth
    send_item(KIND_PACKET, 10'd2);            // waits, only one token
    send_item(KIND_TICK, '1);                 // second token releases it, need bits ignored
    for (int i = 0; i < 10; i++) send_item(KIND_TICK, '0);   // fill to the depth
    send_item(KIND_TICK, '0);                 // bucket full, token dropped
    send_item(KIND_PACKET, 10'd10);           // need equal to the depth, empties the bucket
    send_item(KIND_PACKET, 10'd5);            // blocks the head
    send_item(KIND_PACKET, '0);               // zero need still waits behind the head
    finish_phase(4);

    // limit just ahead of the count so arrivals run past it; spare indexes and a depth
    // write with bits above the field width that must be cut off
    write_reg(CFG_SPARE_LOW, 16'hFFFF);
    write_reg(CFG_SPARE_TOP, 16'h1234);
    write_reg(CFG_BUCKET_DEPTH, 16'hFC0A);
    write_reg(CFG_PACKET_LIMIT, CFG_DATA_W'(packets_numbered + 12));
    end_writes();
    cur_depth = 10;
    run_mix(40);
    finish_phase(4);

    // smallest limits: one, then zero, every arrival ignored
    set_pace(PACE_SEND_GAPS);
    write_reg(CFG_PACKET_LIMIT, 16'd1);
    end_writes();
    run_mix(15);
    finish_phase(4);
    write_reg(CFG_PACKET_LIMIT, 16'd0);
    end_writes();
    run_mix(15);
    finish_phase(4);

    // build the level high, then lower the depth beneath it so ticks get dropped
    set_pace(PACE_RECV_STALLS);
    write_reg(CFG_BUCKET_DEPTH, 16'd1023);
    write_reg(CFG_PACKET_LIMIT, 16'hFFFF);
    end_writes();
    cur_depth = 1023;
    for (int i = 0; i < 30; i++) send_item(KIND_TICK, NEED_IN_W'($urandom));
    finish_phase(4);
    write_reg(CFG_BUCKET_DEPTH, 16'd3);
    end_writes();
    cur_depth = 3;
    run_mix(40);
    finish_phase(4);

    // fifo overflow: empty the fifo and bucket, block the head, then pile arrivals behind it
    set_pace(PACE_BOTH);
    write_reg(CFG_BUCKET_DEPTH, 16'd1023);
    end_writes();
    cur_depth = 1023;
    n = 0;
    while (queued_packets != 0 && n < 300) begin
      send_item(KIND_TICK, '0);
      n++;
    end
    finish_phase(4);
    if (bucket_tokens != 0) send_item(KIND_PACKET, NEED_IN_W'(bucket_tokens));
    send_item(KIND_PACKET, 10'd40);
    for (int i = 0; i < 70; i++) send_item(KIND_PACKET, NEED_IN_W'($urandom_range(3, 0)));
    finish_phase(4);
    // drain mostly with ticks, a few arrivals mixed in
    n = 0;
    while (queued_packets != 0 && n < 400) begin
      if ($urandom_range(99) < 85) send_item(KIND_TICK, NEED_IN_W'($urandom));
      else send_item(KIND_PACKET, NEED_IN_W'($urandom_range(3, 0)));
      n++;
    end
    finish_phase(4);

    // random phases across depths from zero to the top, pacing rotated
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cur_depth = 1023;
        1: cur_depth = 0;
        2: cur_depth = 1;
        3: cur_depth = $urandom_range(40, 2);
        4: cur_depth = $urandom_range(1022, 100);
        default: cur_depth = 10;
      endcase
      k = p % 4;
      set_pace(pace_t'(k));
      write_reg(CFG_BUCKET_DEPTH, CFG_DATA_W'(cur_depth));
      end_writes();
      run_mix(90);
      finish_phase(4);
    end

    finish_phase(8);
    $display("covered %0d items and %0d register writes over %0d phases", items_sent,
             reg_writes, phases);
    $display("including past-limit, zero-limit, lowered-depth and full-fifo cases");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("token_bucket_shaper_test: PASS");
    end else begin
      $display("token_bucket_shaper_test: FAIL");
    end
    $finish;
  end

endmodule
